[sv/nearest_triangle_distance_search_defines.svh]
// Assertion macros for the nearest triangle search RTL.
`ifndef NEAREST_TRIANGLE_DISTANCE_SEARCH_DEFINES_SVH
`define NEAREST_TRIANGLE_DISTANCE_SEARCH_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted.
`define NTDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication built on the macro above.
`define NTDS_ASSERT_IMP(lbl, ante, cons, msg) \
  `NTDS_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[sv/ntds_pkg.sv]
// Types, constants and the arithmetic microprogram of the nearest triangle search.
package ntds_pkg;

  localparam int TRIANGLE_SLOTS = 256;
  localparam int IDX_W = (TRIANGLE_SLOTS > 1) ? $clog2(TRIANGLE_SLOTS) : 1;
  localparam int CNT_W = $clog2(TRIANGLE_SLOTS + 1);
  localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TRIANGLE_SLOTS);

  localparam int ONE_Q16 = 65536;
  localparam int FRAC_W = 17;
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] LAST_TRI_STEP = 6'd35;
  localparam logic [STEP_W-1:0] FIRST_DX_STEP = 6'd36;
  localparam logic [STEP_W-1:0] LAST_STEP = 6'd50;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [15:0] v0_x;
    logic signed [15:0] v0_y;
    logic signed [15:0] v0_z;
    logic signed [15:0] v1_x;
    logic signed [15:0] v1_y;
    logic signed [15:0] v1_z;
    logic signed [15:0] v2_x;
    logic signed [15:0] v2_y;
    logic signed [15:0] v2_z;
  } in_t;

  typedef struct packed {
    logic               found;
    logic [35:0]        dist_sq;
    logic signed [35:0] normal_x;
    logic signed [35:0] normal_y;
    logic signed [35:0] normal_z;
  } out_t;

  // Operand sources of the shared multiplier.
  typedef enum logic [4:0] {
    SRC_AB0, SRC_AB1, SRC_AB2,
    SRC_AC0, SRC_AC1, SRC_AC2,
    SRC_AP0, SRC_AP1, SRC_AP2,
    SRC_BP0, SRC_BP1, SRC_BP2,
    SRC_CP0, SRC_CP1, SRC_CP2,
    SRC_D1, SRC_D2, SRC_D3, SRC_D4, SRC_D5, SRC_D6,
    SRC_DX0, SRC_DX1, SRC_DX2,
    SRC_V, SRC_W, SRC_ONE
  } src_e;

  // Which slice of the B operand enters the multiplier.
  typedef enum logic [1:0] {
    PART_FULL,
    PART_LO,
    PART_HI
  } part_e;

  typedef enum logic [4:0] {
    DST_NONE,
    DST_N0, DST_N1, DST_N2,
    DST_D1, DST_D2, DST_D3, DST_D4, DST_D5, DST_D6,
    DST_VC, DST_VB, DST_VA,
    DST_DX0, DST_DX1, DST_DX2,
    DST_DIST
  } dst_e;

  typedef struct packed {
    src_e  a_src;
    src_e  b_src;
    part_e part;
    logic  neg;
    logic  first;
    dst_e  dest;
  } op_t;

  function automatic op_t mk(input src_e a, input src_e b, input part_e p,
                             input logic ng, input logic fs, input dst_e d);
    op_t o;
    o.a_src = a;
    o.b_src = b;
    o.part  = p;
    o.neg   = ng;
    o.first = fs;
    o.dest  = d;
    return o;
  endfunction

  // One multiply-accumulate per step.
  function automatic op_t prog(input logic [STEP_W-1:0] s);
    op_t o;
    unique case (s)
      // cross product ab x ac
      6'd0:  o = mk(SRC_AB1, SRC_AC2, PART_FULL, 1'b0, 1'b1, DST_NONE);
      6'd1:  o = mk(SRC_AB2, SRC_AC1, PART_FULL, 1'b1, 1'b0, DST_N0);
      6'd2:  o = mk(SRC_AB2, SRC_AC0, PART_FULL, 1'b0, 1'b1, DST_NONE);
      6'd3:  o = mk(SRC_AB0, SRC_AC2, PART_FULL, 1'b1, 1'b0, DST_N1);
      6'd4:  o = mk(SRC_AB0, SRC_AC1, PART_FULL, 1'b0, 1'b1, DST_NONE);
      6'd5:  o = mk(SRC_AB1, SRC_AC0, PART_FULL, 1'b1, 1'b0, DST_N2);
      // six dot products
      6'd6:  o = mk(SRC_AB0, SRC_AP0, PART_FULL, 1'b0, 1'b1, DST_NONE);
      6'd7:  o = mk(SRC_AB1, SRC_AP1, PART_FULL, 1'b0, 1'b0, DST_NONE);
      6'd8:  o = mk(SRC_AB2, SRC_AP2, PART_FULL, 1'b0, 1'b0, DST_D1);
      6'd9:  o = mk(SRC_AC0, SRC_AP0, PART_FULL, 1'b0, 1'b1, DST_NONE);
      6'd10: o = mk(SRC_AC1, SRC_AP1, PART_FULL, 1'b0, 1'b0, DST_NONE);
      6'd11: o = mk(SRC_AC2, SRC_AP2, PART_FULL, 1'b0, 1'b0, DST_D2);
      6'd12: o = mk(SRC_AB0, SRC_BP0, PART_FULL, 1'b0, 1'b1, DST_NONE);
      6'd13: o = mk(SRC_AB1, SRC_BP1, PART_FULL, 1'b0, 1'b0, DST_NONE);
      6'd14: o = mk(SRC_AB2, SRC_BP2, PART_FULL, 1'b0, 1'b0, DST_D3);
      6'd15: o = mk(SRC_AC0, SRC_BP0, PART_FULL, 1'b0, 1'b1, DST_NONE);
      6'd16: o = mk(SRC_AC1, SRC_BP1, PART_FULL, 1'b0, 1'b0, DST_NONE);
      6'd17: o = mk(SRC_AC2, SRC_BP2, PART_FULL, 1'b0, 1'b0, DST_D4);
      6'd18: o = mk(SRC_AB0, SRC_CP0, PART_FULL, 1'b0, 1'b1, DST_NONE);
      6'd19: o = mk(SRC_AB1, SRC_CP1, PART_FULL, 1'b0, 1'b0, DST_NONE);
      6'd20: o = mk(SRC_AB2, SRC_CP2, PART_FULL, 1'b0, 1'b0, DST_D5);
      6'd21: o = mk(SRC_AC0, SRC_CP0, PART_FULL, 1'b0, 1'b1, DST_NONE);
      6'd22: o = mk(SRC_AC1, SRC_CP1, PART_FULL, 1'b0, 1'b0, DST_NONE);
      6'd23: o = mk(SRC_AC2, SRC_CP2, PART_FULL, 1'b0, 1'b0, DST_D6);
      // barycentric numerators, each wide product in two halves
      6'd24: o = mk(SRC_D1, SRC_D4, PART_LO, 1'b0, 1'b1, DST_NONE);
      6'd25: o = mk(SRC_D1, SRC_D4, PART_HI, 1'b0, 1'b0, DST_NONE);
      6'd26: o = mk(SRC_D3, SRC_D2, PART_LO, 1'b1, 1'b0, DST_NONE);
      6'd27: o = mk(SRC_D3, SRC_D2, PART_HI, 1'b1, 1'b0, DST_VC);
      6'd28: o = mk(SRC_D5, SRC_D2, PART_LO, 1'b0, 1'b1, DST_NONE);
      6'd29: o = mk(SRC_D5, SRC_D2, PART_HI, 1'b0, 1'b0, DST_NONE);
      6'd30: o = mk(SRC_D1, SRC_D6, PART_LO, 1'b1, 1'b0, DST_NONE);
      6'd31: o = mk(SRC_D1, SRC_D6, PART_HI, 1'b1, 1'b0, DST_VB);
      6'd32: o = mk(SRC_D3, SRC_D6, PART_LO, 1'b0, 1'b1, DST_NONE);
      6'd33: o = mk(SRC_D3, SRC_D6, PART_HI, 1'b0, 1'b0, DST_NONE);
      6'd34: o = mk(SRC_D5, SRC_D4, PART_LO, 1'b1, 1'b0, DST_NONE);
      6'd35: o = mk(SRC_D5, SRC_D4, PART_HI, 1'b1, 1'b0, DST_VA);
      // offset from the closest point, per axis
      6'd36: o = mk(SRC_AP0, SRC_ONE, PART_FULL, 1'b0, 1'b1, DST_NONE);
      6'd37: o = mk(SRC_AB0, SRC_V, PART_FULL, 1'b1, 1'b0, DST_NONE);
      6'd38: o = mk(SRC_AC0, SRC_W, PART_FULL, 1'b1, 1'b0, DST_DX0);
      6'd39: o = mk(SRC_AP1, SRC_ONE, PART_FULL, 1'b0, 1'b1, DST_NONE);
      6'd40: o = mk(SRC_AB1, SRC_V, PART_FULL, 1'b1, 1'b0, DST_NONE);
      6'd41: o = mk(SRC_AC1, SRC_W, PART_FULL, 1'b1, 1'b0, DST_DX1);
      6'd42: o = mk(SRC_AP2, SRC_ONE, PART_FULL, 1'b0, 1'b1, DST_NONE);
      6'd43: o = mk(SRC_AB2, SRC_V, PART_FULL, 1'b1, 1'b0, DST_NONE);
      6'd44: o = mk(SRC_AC2, SRC_W, PART_FULL, 1'b1, 1'b0, DST_DX2);
      // squared length of the offset
      6'd45: o = mk(SRC_DX0, SRC_DX0, PART_LO, 1'b0, 1'b1, DST_NONE);
      6'd46: o = mk(SRC_DX0, SRC_DX0, PART_HI, 1'b0, 1'b0, DST_NONE);
      6'd47: o = mk(SRC_DX1, SRC_DX1, PART_LO, 1'b0, 1'b0, DST_NONE);
      6'd48: o = mk(SRC_DX1, SRC_DX1, PART_HI, 1'b0, 1'b0, DST_NONE);
      6'd49: o = mk(SRC_DX2, SRC_DX2, PART_LO, 1'b0, 1'b0, DST_NONE);
      6'd50: o = mk(SRC_DX2, SRC_DX2, PART_HI, 1'b0, 1'b0, DST_DIST);
      default: o = mk(SRC_ONE, SRC_ONE, PART_FULL, 1'b0, 1'b1, DST_NONE);
    endcase
    return o;
  endfunction

endpackage

[sv/nearest_triangle_distance_search.sv]
// Nearest triangle distance search: triangle table, shared multiply-accumulate unit, sequencer.

// The block keeps up to ntds_pkg::TRIANGLE_SLOTS triangles in three vertex memories and takes one
// transaction at a time on the input channel. Clear and load finish in the cycle they are
// accepted; a load into a full table is dropped. A query visits the stored triangles in load
// order and returns one result transaction: found, the smallest squared distance (Q36.0) from
// the point to each triangle's closest point, and the ab x ac normal of the first triangle that
// reaches it; an empty table gives found = 0 and zeros. A triangle needs no division when its
// closest point is a vertex or the triangle is skipped by the region test, one on an edge and
// two in the face. The time per triangle is set by the single 37 x 19 bit multiply-accumulate
// unit, which runs 51 steps per triangle, and by the restoring divider, which produces one
// quotient bit per cycle for each edge or face weight. The input channel is not ready while a
// query runs; a finished result waits in the output register, and the next transaction may be
// accepted meanwhile.

`include "nearest_triangle_distance_search_defines.svh"

module nearest_triangle_distance_search (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ntds_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output ntds_pkg::out_t out_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_OPS,
    S_DECIDE,
    S_DIV,
    S_DX,
    S_CMP,
    S_DONE
  } state_e;

  // Closest-point region of the current triangle.
  typedef enum logic [2:0] {
    RG_NONE,
    RG_V1,
    RG_W1,
    RG_AB,
    RG_AC,
    RG_BC,
    RG_FACE
  } region_e;

  // Where a finished quotient goes.
  typedef enum logic [1:0] {
    DV_V,
    DV_W,
    DV_BC,
    DV_FACE_V
  } div_dst_e;

  localparam logic [ntds_pkg::FRAC_W-1:0] ONE_FR = ntds_pkg::FRAC_W'(ntds_pkg::ONE_Q16);

  // ---------------------------------------------------------------- control state
  state_e                          state_q;
  logic [ntds_pkg::STEP_W-1:0]     step_q;
  logic [ntds_pkg::CNT_W-1:0]      cnt_q;
  logic [ntds_pkg::IDX_W-1:0]      idx_q;
  logic                            found_q;
  logic [3:0]                      dcnt_q;
  logic                            out_valid_q;
  ntds_pkg::out_t                  out_q;

  // ---------------------------------------------------------------- datapath registers
  logic [47:0]                     mem0 [ntds_pkg::TRIANGLE_SLOTS];
  logic [47:0]                     mem1 [ntds_pkg::TRIANGLE_SLOTS];
  logic [47:0]                     mem2 [ntds_pkg::TRIANGLE_SLOTS];
  logic [47:0]                     rd0_q, rd1_q, rd2_q;
  logic signed [15:0]              p_q [3];
  logic signed [79:0]              acc_q;
  logic signed [35:0]              n0_q, n1_q, n2_q;
  logic signed [35:0]              d1_q, d2_q, d3_q, d4_q, d5_q, d6_q;
  logic signed [71:0]              vc_q, vb_q, va_q;
  logic signed [73:0]              fden_q;
  logic signed [35:0]              dx0_q, dx1_q, dx2_q;
  logic [35:0]                     dist_q;
  logic [ntds_pkg::FRAC_W-1:0]     v_q, w_q;
  logic [73:0]                     num_q, den_q;
  logic [15:0]                     q_q;
  logic                            sat_q;
  div_dst_e                        dst_q;
  logic [35:0]                     best_q;
  logic signed [35:0]              bn0_q, bn1_q, bn2_q;

  // ---------------------------------------------------------------- handshake
  logic in_acc;
  logic load_wr;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign load_wr     = in_acc && (in_i.cmd == ntds_pkg::CMD_LOAD) &&
                       (cnt_q < ntds_pkg::SLOTS_CNT);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // ---------------------------------------------------------------- vertex memories
  // Write at the fill count on load, read the triangle under visit every cycle.
  always_ff @(posedge clk_i) begin
    if (load_wr) begin
      mem0[cnt_q[ntds_pkg::IDX_W-1:0]] <= {in_i.v0_z, in_i.v0_y, in_i.v0_x};
      mem1[cnt_q[ntds_pkg::IDX_W-1:0]] <= {in_i.v1_z, in_i.v1_y, in_i.v1_x};
      mem2[cnt_q[ntds_pkg::IDX_W-1:0]] <= {in_i.v2_z, in_i.v2_y, in_i.v2_x};
    end
    rd0_q <= mem0[idx_q];
    rd1_q <= mem1[idx_q];
    rd2_q <= mem2[idx_q];
  end

  // ---------------------------------------------------------------- edge vectors
  logic signed [16:0] ab [3];
  logic signed [16:0] ac [3];
  logic signed [16:0] ap [3];
  logic signed [16:0] bp [3];
  logic signed [16:0] cp [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ab[k] = 17'($signed(rd1_q[16*k +: 16])) - 17'($signed(rd0_q[16*k +: 16]));
      ac[k] = 17'($signed(rd2_q[16*k +: 16])) - 17'($signed(rd0_q[16*k +: 16]));
      ap[k] = 17'(p_q[k]) - 17'($signed(rd0_q[16*k +: 16]));
      bp[k] = 17'(p_q[k]) - 17'($signed(rd1_q[16*k +: 16]));
      cp[k] = 17'(p_q[k]) - 17'($signed(rd2_q[16*k +: 16]));
    end
  end

  // ---------------------------------------------------------------- shared MAC unit
  function automatic logic signed [36:0] pick(input ntds_pkg::src_e c);
    logic signed [36:0] r;
    unique case (c)
      ntds_pkg::SRC_AB0: r = 37'(ab[0]);
      ntds_pkg::SRC_AB1: r = 37'(ab[1]);
      ntds_pkg::SRC_AB2: r = 37'(ab[2]);
      ntds_pkg::SRC_AC0: r = 37'(ac[0]);
      ntds_pkg::SRC_AC1: r = 37'(ac[1]);
      ntds_pkg::SRC_AC2: r = 37'(ac[2]);
      ntds_pkg::SRC_AP0: r = 37'(ap[0]);
      ntds_pkg::SRC_AP1: r = 37'(ap[1]);
      ntds_pkg::SRC_AP2: r = 37'(ap[2]);
      ntds_pkg::SRC_BP0: r = 37'(bp[0]);
      ntds_pkg::SRC_BP1: r = 37'(bp[1]);
      ntds_pkg::SRC_BP2: r = 37'(bp[2]);
      ntds_pkg::SRC_CP0: r = 37'(cp[0]);
      ntds_pkg::SRC_CP1: r = 37'(cp[1]);
      ntds_pkg::SRC_CP2: r = 37'(cp[2]);
      ntds_pkg::SRC_D1:  r = 37'(d1_q);
      ntds_pkg::SRC_D2:  r = 37'(d2_q);
      ntds_pkg::SRC_D3:  r = 37'(d3_q);
      ntds_pkg::SRC_D4:  r = 37'(d4_q);
      ntds_pkg::SRC_D5:  r = 37'(d5_q);
      ntds_pkg::SRC_D6:  r = 37'(d6_q);
      ntds_pkg::SRC_DX0: r = 37'(dx0_q);
      ntds_pkg::SRC_DX1: r = 37'(dx1_q);
      ntds_pkg::SRC_DX2: r = 37'(dx2_q);
      ntds_pkg::SRC_V:   r = $signed(37'(v_q));
      ntds_pkg::SRC_W:   r = $signed(37'(w_q));
      ntds_pkg::SRC_ONE: r = $signed(37'(ONE_FR));
      default:           r = '0;
    endcase
    return r;
  endfunction

  ntds_pkg::op_t       op;
  logic signed [36:0]  a_val;
  logic signed [36:0]  b_full;
  logic signed [18:0]  b_op;
  logic signed [55:0]  prod;
  logic signed [79:0]  term;
  logic signed [79:0]  acc_d;
  logic [35:0]         dist_d;

  assign op = ntds_pkg::prog(step_q);

  always_comb begin
    a_val  = pick(op.a_src);
    b_full = pick(op.b_src);
    unique case (op.part)
      ntds_pkg::PART_LO: b_op = $signed({1'b0, b_full[17:0]});
      ntds_pkg::PART_HI: b_op = b_full[36:18];
      default:           b_op = b_full[18:0];
    endcase
  end

  assign prod   = a_val * b_op;
  assign term   = (op.part == ntds_pkg::PART_HI) ? (80'(prod) <<< 18) : 80'(prod);
  assign acc_d  = (op.first ? 80'sd0 : acc_q) + (op.neg ? -term : term);
  // Squared distance in Q36.0, saturated.
  assign dist_d = (|acc_d[79:68]) ? '1 : acc_d[67:32];

  // ---------------------------------------------------------------- region test
  logic signed [36:0] e43, e56;
  logic               vc_le, vb_le, va_le;
  logic signed [73:0] fsum;
  region_e            region;

  assign e43   = 37'(d4_q) - 37'(d3_q);
  assign e56   = 37'(d5_q) - 37'(d6_q);
  assign vc_le = vc_q[71] || (vc_q == '0);
  assign vb_le = vb_q[71] || (vb_q == '0);
  assign va_le = va_q[71] || (va_q == '0);
  assign fsum  = 74'(va_q) + 74'(vb_q) + 74'(vc_q);

  always_comb begin
    priority if (d1_q <= 0 && d2_q <= 0)                region = RG_NONE;
    else if (d3_q >= 0 && d4_q <= d3_q)                 region = RG_V1;
    else if (d6_q >= 0 && d5_q <= d6_q)                 region = RG_W1;
    else if (vc_le && d1_q >= 0 && d3_q <= 0)           region = RG_AB;
    else if (vb_le && d2_q >= 0 && d6_q <= 0)           region = RG_AC;
    else if (va_le && e43 >= 0 && e56 >= 0)             region = RG_BC;
    else                                                region = RG_FACE;
  end

  // ---------------------------------------------------------------- divider operands
  // Fraction num/den in Q1.16, truncated, limited to [0, 1].
  logic signed [73:0] sn, sd;
  logic               sbad, ssat;

  always_comb begin
    sn = 74'(vc_q);
    sd = fden_q;
    if (state_q == S_DECIDE) begin
      unique case (region)
        RG_AB: begin
          sn = 74'(d1_q);
          sd = 74'(37'(d1_q) - 37'(d3_q));
        end
        RG_AC: begin
          sn = 74'(d2_q);
          sd = 74'(37'(d2_q) - 37'(d6_q));
        end
        RG_BC: begin
          sn = 74'(e43);
          sd = 74'(38'(e43) + 38'(e56));
        end
        default: begin
          sn = 74'(vb_q);
          sd = fsum;
        end
      endcase
    end
  end

  assign sbad = (sd <= 0) || (sn <= 0);
  assign ssat = !sbad && (sn >= sd);

  logic [73:0]                 num2;
  logic                        dge;
  logic [15:0]                 qn;
  logic [ntds_pkg::FRAC_W-1:0] dres;
  logic                        div_last;
  logic                        div_start;

  assign num2     = {num_q[72:0], 1'b0};
  assign dge      = (num2 >= den_q);
  assign qn       = {q_q[14:0], dge};
  assign dres     = sat_q ? ONE_FR : {1'b0, qn};
  assign div_last = (state_q == S_DIV) && (dcnt_q == 4'd15);
  assign div_start = ((state_q == S_DECIDE) &&
                      (region == RG_AB || region == RG_AC ||
                       region == RG_BC || region == RG_FACE)) ||
                     (div_last && dst_q == DV_FACE_V);

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.cmd == ntds_pkg::CMD_QUERY) begin
      p_q[0] <= in_i.v0_x;
      p_q[1] <= in_i.v0_y;
      p_q[2] <= in_i.v0_z;
      best_q <= '0;
      bn0_q  <= '0;
      bn1_q  <= '0;
      bn2_q  <= '0;
    end

    if (state_q == S_OPS || state_q == S_DX) begin
      acc_q <= acc_d;
      unique case (op.dest)
        ntds_pkg::DST_N0:   n0_q   <= acc_d[35:0];
        ntds_pkg::DST_N1:   n1_q   <= acc_d[35:0];
        ntds_pkg::DST_N2:   n2_q   <= acc_d[35:0];
        ntds_pkg::DST_D1:   d1_q   <= acc_d[35:0];
        ntds_pkg::DST_D2:   d2_q   <= acc_d[35:0];
        ntds_pkg::DST_D3:   d3_q   <= acc_d[35:0];
        ntds_pkg::DST_D4:   d4_q   <= acc_d[35:0];
        ntds_pkg::DST_D5:   d5_q   <= acc_d[35:0];
        ntds_pkg::DST_D6:   d6_q   <= acc_d[35:0];
        ntds_pkg::DST_VC:   vc_q   <= acc_d[71:0];
        ntds_pkg::DST_VB:   vb_q   <= acc_d[71:0];
        ntds_pkg::DST_VA:   va_q   <= acc_d[71:0];
        ntds_pkg::DST_DX0:  dx0_q  <= acc_d[35:0];
        ntds_pkg::DST_DX1:  dx1_q  <= acc_d[35:0];
        ntds_pkg::DST_DX2:  dx2_q  <= acc_d[35:0];
        ntds_pkg::DST_DIST: dist_q <= dist_d;
        default: ;
      endcase
    end

    if (state_q == S_DECIDE) begin
      fden_q <= fsum;
      v_q    <= (region == RG_V1) ? ONE_FR : '0;
      w_q    <= (region == RG_W1) ? ONE_FR : '0;
      unique case (region)
        RG_AB:   dst_q <= DV_V;
        RG_AC:   dst_q <= DV_W;
        RG_BC:   dst_q <= DV_BC;
        default: dst_q <= DV_FACE_V;
      endcase
    end

    // A fresh start takes the divider over; otherwise advance one quotient bit.
    if (div_start) begin
      num_q <= sbad ? '0 : sn;
      den_q <= sbad ? 74'd1 : sd;
      sat_q <= ssat;
      q_q   <= '0;
    end else if (state_q == S_DIV) begin
      num_q <= dge ? (num2 - den_q) : num2;
      q_q   <= qn;
    end

    if (div_last) begin
      unique case (dst_q)
        DV_V: v_q <= dres;
        DV_W: w_q <= dres;
        DV_BC: begin
          w_q <= dres;
          v_q <= ONE_FR - dres;
        end
        default: begin
          v_q   <= dres;
          dst_q <= DV_W;
        end
      endcase
    end

    // Strict compare: a tie keeps the earlier triangle.
    if (state_q == S_CMP && (!found_q || dist_q < best_q)) begin
      best_q <= dist_q;
      bn0_q  <= n0_q;
      bn1_q  <= n1_q;
      bn2_q  <= n2_q;
    end
  end

  // ---------------------------------------------------------------- sequencer
  logic idx_last;

  assign idx_last = ((ntds_pkg::CNT_W'(idx_q) + 1'b1) == cnt_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      found_q     <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Drop the result once taken, unless a finished query reloads it below.
      if (out_valid_q && out_ready_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (in_i.cmd)
              ntds_pkg::CMD_CLEAR: cnt_q <= '0;
              ntds_pkg::CMD_LOAD: begin
                if (load_wr) begin
                  cnt_q <= cnt_q + 1'b1;
                end
              end
              ntds_pkg::CMD_QUERY: begin
                idx_q   <= '0;
                found_q <= 1'b0;
                state_q <= (cnt_q == '0) ? S_DONE : S_RD;
              end
              default: ;
            endcase
          end
        end
        S_RD: begin
          step_q  <= '0;
          state_q <= S_OPS;
        end
        S_OPS: begin
          step_q <= step_q + 1'b1;
          if (step_q == ntds_pkg::LAST_TRI_STEP) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          dcnt_q <= '0;
          step_q <= ntds_pkg::FIRST_DX_STEP;
          if (div_start) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_DX;
          end
        end
        S_DIV: begin
          dcnt_q <= dcnt_q + 1'b1;
          if (div_last && dst_q != DV_FACE_V) begin
            state_q <= S_DX;
          end
        end
        S_DX: begin
          step_q <= step_q + 1'b1;
          if (step_q == ntds_pkg::LAST_STEP) begin
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          found_q <= 1'b1;
          idx_q   <= idx_q + 1'b1;
          state_q <= idx_last ? S_DONE : S_RD;
        end
        S_DONE: begin
          // Hold the result until the output register is free.
          if (!out_valid_q || out_ready_i) begin
            out_valid_q      <= 1'b1;
            out_q.found      <= found_q;
            out_q.dist_sq    <= best_q;
            out_q.normal_x   <= bn0_q;
            out_q.normal_y   <= bn1_q;
            out_q.normal_z   <= bn2_q;
            state_q          <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------- assertions
  `NTDS_ASSERT(a_cnt_range, cnt_q <= ntds_pkg::SLOTS_CNT, "triangle count beyond table size")
  `NTDS_ASSERT_IMP(a_empty_zero, out_valid_o && !out_o.found, out_o.dist_sq == '0 && out_o.normal_x == '0 && out_o.normal_y == '0 && out_o.normal_z == '0, "empty result not zero")
  `NTDS_ASSERT_IMP(a_result_src, $rose(out_valid_o), $past(state_q == S_DONE), "result without finished query")
  `NTDS_ASSERT_IMP(a_ops_step, state_q == S_OPS, step_q <= ntds_pkg::LAST_TRI_STEP, "step beyond triangle program")

endmodule

[sim/testbench.sv]
// Self-checking testbench for the nearest triangle distance search block.
`timescale 1ns / 100ps

module testbench;

  // Command code that the block must ignore: no result and no state change.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam longint     ONE_Q16_L = 64'sd65536;
  localparam int         CYCLE_LIMIT = 4000000;
  localparam int         ITEM_TARGET = 500;

  typedef logic signed [127:0] wide_t;

  // Scoreboard: holds its own copy of the triangle table, computes the
  // expected query results and compares them with what the block returns.
  class nearest_search_scoreboard;
    ntds_pkg::in_t  tri_table [ntds_pkg::TRIANGLE_SLOTS];
    int unsigned    tri_count;
    ntds_pkg::out_t expected_results [$];
    int             mismatches;

    function new();
      tri_count  = 0;
      mismatches = 0;
    endfunction

    task report(input string what, input logic [35:0] got, input logic [35:0] want);
      $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
      mismatches++;
    endtask

    function longint edge_param(input longint num, input longint den);
      longint t;
      if (den <= 0 || num <= 0) return 0;
      t = (num * ONE_Q16_L) / den;
      return (t > ONE_Q16_L) ? ONE_Q16_L : t;
    endfunction

    function longint face_weight(input wide_t num, input wide_t den);
      wide_t q;
      if (den <= 0 || num <= 0) return 0;
      if (num >= den) return ONE_Q16_L;
      q = (num <<< 16) / den;
      return longint'(q);
    endfunction

    function longint dot3(input longint u [3], input longint v [3]);
      return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    // Squared distance from p to its closest point on triangle abc, plus the
    // unnormalised normal ab x ac.
    function logic [35:0] closest_dist_sq(input longint p [3], input longint a [3],
                                          input longint b [3], input longint c [3],
                                          output longint n [3]);
      longint ab [3], ac [3], ap [3], bp [3], cp [3];
      longint d1, d2, d3, d4, d5, d6, v, w, t, offset;
      wide_t  vc, vb, va, den, acc;
      for (int k = 0; k < 3; k++) begin
        ab[k] = b[k] - a[k];
        ac[k] = c[k] - a[k];
        ap[k] = p[k] - a[k];
        bp[k] = p[k] - b[k];
        cp[k] = p[k] - c[k];
      end
      n[0] = ab[1] * ac[2] - ab[2] * ac[1];
      n[1] = ab[2] * ac[0] - ab[0] * ac[2];
      n[2] = ab[0] * ac[1] - ab[1] * ac[0];
      v  = 0;
      w  = 0;
      d1 = dot3(ab, ap);
      d2 = dot3(ac, ap);
      if (!(d1 <= 0 && d2 <= 0)) begin
        d3 = dot3(ab, bp);
        d4 = dot3(ac, bp);
        d5 = dot3(ab, cp);
        d6 = dot3(ac, cp);
        vc = wide_t'(d1) * wide_t'(d4) - wide_t'(d3) * wide_t'(d2);
        vb = wide_t'(d5) * wide_t'(d2) - wide_t'(d1) * wide_t'(d6);
        va = wide_t'(d3) * wide_t'(d6) - wide_t'(d5) * wide_t'(d4);
        if (d3 >= 0 && d4 <= d3) begin
          v = ONE_Q16_L;
        end else if (d6 >= 0 && d5 <= d6) begin
          w = ONE_Q16_L;
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
          v = edge_param(d1, d1 - d3);
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
          w = edge_param(d2, d2 - d6);
        end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
          t = edge_param(d4 - d3, (d4 - d3) + (d5 - d6));
          v = ONE_Q16_L - t;
          w = t;
        end else begin
          den = va + vb + vc;
          v   = face_weight(vb, den);
          w   = face_weight(vc, den);
        end
      end
      acc = 0;
      for (int k = 0; k < 3; k++) begin
        offset = ap[k] * ONE_Q16_L - ab[k] * v - ac[k] * w;
        acc += wide_t'(offset) * wide_t'(offset);
      end
      if (acc >= (wide_t'(1) <<< 68)) return '1;
      return acc[67:32];
    endfunction

    // Note a transaction accepted on the input channel.
    function void note_input(input ntds_pkg::in_t item);
      longint p [3], a [3], b [3], c [3], n [3], best_n [3];
      logic [35:0] d, best;
      bit   hit;
      ntds_pkg::out_t res;
      case (item.cmd)
        ntds_pkg::CMD_CLEAR: tri_count = 0;
        ntds_pkg::CMD_LOAD: begin
          if (tri_count < ntds_pkg::TRIANGLE_SLOTS) begin
            tri_table[tri_count] = item;
            tri_count++;
          end
        end
        ntds_pkg::CMD_QUERY: begin
          p[0] = $signed(item.v0_x);
          p[1] = $signed(item.v0_y);
          p[2] = $signed(item.v0_z);
          hit  = 0;
          best = '0;
          best_n = '{0, 0, 0};
          for (int i = 0; i < tri_count; i++) begin
            a = '{$signed(tri_table[i].v0_x), $signed(tri_table[i].v0_y),
                  $signed(tri_table[i].v0_z)};
            b = '{$signed(tri_table[i].v1_x), $signed(tri_table[i].v1_y),
                  $signed(tri_table[i].v1_z)};
            c = '{$signed(tri_table[i].v2_x), $signed(tri_table[i].v2_y),
                  $signed(tri_table[i].v2_z)};
            d = closest_dist_sq(p, a, b, c, n);
            // strict compare: a tie keeps the earlier triangle
            if (!hit || d < best) begin
              hit    = 1;
              best   = d;
              best_n = n;
            end
          end
          res.found    = hit;
          res.dist_sq  = best;
          res.normal_x = best_n[0][35:0];
          res.normal_y = best_n[1][35:0];
          res.normal_z = best_n[2][35:0];
          expected_results = {expected_results, res};
        end
        default: ;
      endcase
    endfunction

    // Compare a returned result against the oldest expectation.
    task check_result(input ntds_pkg::out_t got);
      ntds_pkg::out_t want;
      if (expected_results.size() == 0) begin
        report("unexpected result", 36'(got.found), 36'(1'b0));
        return;
      end
      want = expected_results.pop_front();
      if (got.found !== want.found)       report("found", 36'(got.found), 36'(want.found));
      if (got.dist_sq !== want.dist_sq)   report("dist_sq", got.dist_sq, want.dist_sq);
      if (got.normal_x !== want.normal_x) report("normal_x", got.normal_x, want.normal_x);
      if (got.normal_y !== want.normal_y) report("normal_y", got.normal_y, want.normal_y);
      if (got.normal_z !== want.normal_z) report("normal_z", got.normal_z, want.normal_z);
    endtask
  endclass

  logic           clk_i;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  ntds_pkg::in_t  in_i;
  logic           out_valid_o;
  logic           out_ready_i;
  ntds_pkg::out_t out_o;

  nearest_search_scoreboard search_sb;
  int   cycle_count;
  int   items_sent;
  bit   sender_busy_stretch;

  nearest_triangle_distance_search u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  always #10 clk_i = ~clk_i;

  // Watchdog: end the run if it drags on far beyond the slowest correct run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Take every result transaction to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) search_sb.check_result(out_o);
  end

  // Receiver stalls: mostly short, now and then long, with long stall-free runs.
  initial begin
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      out_ready_i <= 1'b1;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(50, 300)) @(posedge clk_i);
      else repeat ($urandom_range(1, 12)) @(posedge clk_i);
      out_ready_i <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 60)) @(posedge clk_i);
      else repeat ($urandom_range(0, 3)) @(posedge clk_i);
    end
  end

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0: return -16'sd32768;
          1: return 16'sd32767;
          2: return 16'sd0;
          default: return -16'sd1;
        endcase
      end
      // keep most geometry within +-1024 so the regions get mixed
      default: return 16'($signed($urandom_range(0, 2048)) - 1024);
    endcase
  endfunction

  function automatic ntds_pkg::in_t rand_load();
    ntds_pkg::in_t it;
    it.cmd  = ntds_pkg::CMD_LOAD;
    it.v0_x = rand_coord(); it.v0_y = rand_coord(); it.v0_z = rand_coord();
    it.v1_x = rand_coord(); it.v1_y = rand_coord(); it.v1_z = rand_coord();
    it.v2_x = rand_coord(); it.v2_y = rand_coord(); it.v2_z = rand_coord();
    case ($urandom_range(0, 9))
      // collapse an edge
      0: begin it.v1_x = it.v0_x; it.v1_y = it.v0_y; it.v1_z = it.v0_z; end
      // collinear vertices
      1: begin
        it.v2_x = it.v1_x + (it.v1_x - it.v0_x);
        it.v2_y = it.v1_y + (it.v1_y - it.v0_y);
        it.v2_z = it.v1_z + (it.v1_z - it.v0_z);
      end
      // a single point
      2: begin
        it.v1_x = it.v0_x; it.v1_y = it.v0_y; it.v1_z = it.v0_z;
        it.v2_x = it.v0_x; it.v2_y = it.v0_y; it.v2_z = it.v0_z;
      end
      default: ;
    endcase
    return it;
  endfunction

  function automatic ntds_pkg::in_t rand_query();
    ntds_pkg::in_t it;
    it      = rand_load();
    it.cmd  = ntds_pkg::CMD_QUERY;
    it.v0_x = rand_coord(); it.v0_y = rand_coord(); it.v0_z = rand_coord();
    return it;
  endfunction

  function automatic ntds_pkg::in_t make_item(input logic [1:0] cmd,
                                              input logic signed [15:0] c0, c1, c2, c3, c4,
                                              input logic signed [15:0] c5, c6, c7, c8);
    ntds_pkg::in_t it;
    it.cmd = cmd;
    it.v0_x = c0; it.v0_y = c1; it.v0_z = c2;
    it.v1_x = c3; it.v1_y = c4; it.v1_z = c5;
    it.v2_x = c6; it.v2_y = c7; it.v2_z = c8;
    return it;
  endfunction

  // Query at a point; the vertex fields stay zero.
  function automatic ntds_pkg::in_t query_at(input logic signed [15:0] x, y, z);
    return make_item(ntds_pkg::CMD_QUERY, x, y, z, '0, '0, '0, '0, '0, '0);
  endfunction

  function automatic ntds_pkg::in_t clear_item();
    return make_item(ntds_pkg::CMD_CLEAR, '0, '0, '0, '0, '0, '0, '0, '0, '0);
  endfunction

  // Drive one transaction: idle for a random gap, then hold valid until accepted.
  task automatic send(input ntds_pkg::in_t item);
    int gap;
    if (sender_busy_stretch) gap = 0;
    else begin
      case ($urandom_range(0, 9))
        0:       gap = $urandom_range(10, 60);
        1, 2, 3: gap = $urandom_range(1, 3);
        default: gap = 0;
      endcase
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    do @(posedge clk_i); while (!in_ready_o);
    search_sb.note_input(item);
    items_sent++;
  endtask

  // Hold off until every expected result has come back.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (search_sb.expected_results.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  initial begin
    search_sb    = new();
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_i         = '0;
    cycle_count  = 0;
    items_sent   = 0;
    sender_busy_stretch = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extremes, degenerate shapes, each region.
    send(query_at(16'sd256, -16'sd256, 16'sd0));
    send(make_item(CMD_UNUSED, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1,
                   -16'sd1, -16'sd1, -16'sd1));
    send(query_at(16'sd0, 16'sd0, 16'sd0));
    send(make_item(ntds_pkg::CMD_LOAD, 16'sd0, 16'sd0, 16'sd0, 16'sd1024, 16'sd0, 16'sd0,
                   16'sd0, 16'sd1024, 16'sd0));
    send(query_at(-16'sd256, -16'sd256, 16'sd0));   // vertex a
    send(query_at(16'sd1536, -16'sd10, 16'sd5));    // vertex b
    send(query_at(16'sd3, 16'sd2000, 16'sd0));      // vertex c
    send(query_at(16'sd512, -16'sd300, 16'sd7));    // edge ab
    send(query_at(-16'sd300, 16'sd512, 16'sd7));    // edge ac
    send(query_at(16'sd700, 16'sd700, -16'sd9));    // edge bc
    send(query_at(16'sd200, 16'sd300, 16'sd256));   // face
    send(make_item(ntds_pkg::CMD_LOAD, -16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767,
                   16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd32767));
    send(make_item(ntds_pkg::CMD_LOAD, 16'sd100, 16'sd100, 16'sd100, 16'sd100, 16'sd100,
                   16'sd100, 16'sd100, 16'sd100, 16'sd100));                       // point
    send(make_item(ntds_pkg::CMD_LOAD, 16'sd0, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd0,
                   16'sd512, 16'sd512, 16'sd0));                                   // collinear
    send(query_at(16'sd32767, 16'sd32767, 16'sd32767));
    send(query_at(-16'sd32768, -16'sd32768, -16'sd32768));
    send(query_at(16'sd100, 16'sd100, 16'sd100));
    send(query_at(16'sd384, 16'sd384, 16'sd0));
    send(clear_item());
    send(query_at(16'sd1, 16'sd1, 16'sd1));
    drain();

    // Fill the table to the brim; the extra loads must be dropped.
    send(clear_item());
    for (int i = 0; i < ntds_pkg::TRIANGLE_SLOTS + 3; i++) send(rand_load());
    send(rand_query());
    send(rand_query());
    send(clear_item());

    // Random: clear, load a handful of triangles, query several points.
    for (int seq = 0; items_sent < ITEM_TARGET; seq++) begin
      sender_busy_stretch = ($urandom_range(0, 5) == 0);
      if (seq % 15 == 7) drain();
      if ($urandom_range(0, 3) != 0) send(make_item(ntds_pkg::CMD_CLEAR, rand_coord(),
        rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(), rand_coord(),
        rand_coord(), rand_coord()));
      repeat ($urandom_range(0, 8)) send(rand_load());
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 9) == 0) begin
          send(make_item(CMD_UNUSED, rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                         rand_coord(), rand_coord()));
        end
        send(rand_query());
      end
    end
    sender_busy_stretch = 0;

    // Wind down: let every outstanding result arrive, then allow a margin.
    drain();
    repeat (200) @(posedge clk_i);
    if (search_sb.mismatches == 0 && search_sb.expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
